// File: src/mbrw_pkg.sv
// Package for the Modbus RTU read/write slave.
// Holds the payload structs, the sequencer states, the function codes and the CRC step.
// No dependencies.
`default_nettype none

package mbrw_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } tx_item_t;

  typedef enum logic [2:0] {
    S_CLEAR_MEM,
    S_IDLE,
    S_RX_SHIFT,
    S_CHECK,
    S_RD_REQ,
    S_TX_BYTE,
    S_TX_SHIFT
  } state_t;

  localparam logic [7:0]  FN_READ  = 8'h03;
  localparam logic [7:0]  FN_WRITE = 8'h06;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // One bit of the reflected Modbus CRC-16.
  function automatic logic [15:0] crc_step(input logic [15:0] c);
    logic [15:0] s;
    s = {1'b0, c[15:1]};
    if (c[0]) begin
      s = s ^ CRC_POLY;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: src/mbrw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the holding register file. No dependencies.
`default_nettype none

module mbrw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/modbus_rtu_slave_read_write_unit.sv
// Top level of the Modbus RTU slave for read holding registers and write single register.
// Depends on mbrw_pkg and mbrw_ram.
`default_nettype none

// Channel   Handshake            Payload
// rx        rx_valid / rx_stall  rx_data  (rx_byte, frame_end)
// tx        tx_valid / tx_stall  tx_data  (tx_byte, tx_last)
// cfg       cfg_wr_en            cfg_wr_data (device address)
//
// The first two bytes of a frame are taken in S_IDLE alone; each later byte also passes through
// S_RX_SHIFT, since the bit-serial CRC unit shifts one bit per cycle. The last byte adds S_CHECK.
// Each response byte before the CRC passes S_TX_BYTE and S_TX_SHIFT on the same CRC unit, each
// read register adds S_RD_REQ for its RAM read, and the two CRC bytes are sent from S_TX_BYTE.
// After reset a clearing pass in S_CLEAR_MEM zeroes the register file; rx is stalled.
// A full output register held by tx_stall pauses the response until the byte is taken.

module modbus_rtu_slave_read_write_unit #(
  parameter int REG_COUNT = 64,
  parameter int MAX_READ  = 16,
  parameter int MAX_FRAME = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [7:0]          cfg_wr_data,
  input  wire logic                rx_valid,
  output logic                     rx_stall,
  input  wire mbrw_pkg::rx_item_t  rx_data,
  output logic                     tx_valid,
  input  wire logic                tx_stall,
  output mbrw_pkg::tx_item_t       tx_data
);

  import mbrw_pkg::*;

  localparam int ADDR_W   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int LEN_W    = $clog2(MAX_FRAME + 2);
  localparam int TX_IDX_W = $clog2(6 + 2 * MAX_READ);

  state_t              state, state_next;
  logic [2:0]          bit_cnt, bit_cnt_next;
  logic [LEN_W-1:0]    len, len_next;
  logic [15:0]         trailing, trailing_next;
  logic [15:0]         crc, crc_next;
  logic [7:0]          hdr [6];
  logic [7:0]          hdr_next [6];
  logic [7:0]          dev_addr, dev_addr_next;
  logic [ADDR_W-1:0]   clr_addr, clr_addr_next;
  logic                frame_last, frame_last_next;
  logic                is_read, is_read_next;
  logic [TX_IDX_W-1:0] data_end, data_end_next;
  logic [TX_IDX_W-1:0] tx_idx, tx_idx_next;
  logic [ADDR_W-1:0]   rd_ptr, rd_ptr_next;
  logic                out_valid, out_valid_next;
  tx_item_t            out_data, out_data_next;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [15:0]         ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [15:0]         ram_rdata;

  logic                out_free;
  logic                load_last;
  logic [15:0]         reg_a;
  logic [15:0]         reg_v;
  logic [16:0]         range_end;
  logic                frame_ok;
  logic                read_ok;
  logic                write_ok;
  logic [7:0]          sel_byte;
  logic [TX_IDX_W-1:0] idx_inc;

  mbrw_ram #(
    .WIDTH(16),
    .DEPTH(REG_COUNT)
  ) u_regs (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rx_stall = (state != S_IDLE);
  assign tx_valid = out_valid;
  assign tx_data  = out_data;
  assign out_free = !out_valid || !tx_stall;

  assign reg_a     = {hdr[2], hdr[3]};
  assign reg_v     = {hdr[4], hdr[5]};
  assign range_end = {1'b0, reg_a} + {1'b0, reg_v};
  assign frame_ok  = (len >= LEN_W'(4)) && (len <= LEN_W'(MAX_FRAME)) &&
                     ({trailing[7:0], trailing[15:8]} == crc) && (hdr[0] == dev_addr);
  assign read_ok   = (hdr[1] == FN_READ) && (reg_v != 16'd0) &&
                     (reg_v <= 16'(MAX_READ)) && (range_end <= 17'(REG_COUNT));
  assign write_ok  = (hdr[1] == FN_WRITE) && ({1'b0, reg_a} < 17'(REG_COUNT));
  assign idx_inc   = tx_idx + 1'b1;

  always_comb begin
    if (tx_idx == TX_IDX_W'(0)) begin
      sel_byte = dev_addr;
    end else if (tx_idx == TX_IDX_W'(1)) begin
      sel_byte = is_read ? FN_READ : FN_WRITE;
    end else if (tx_idx == TX_IDX_W'(2)) begin
      sel_byte = is_read ? {reg_v[6:0], 1'b0} : hdr[2];
    end else if (is_read) begin
      sel_byte = tx_idx[0] ? ram_rdata[15:8] : ram_rdata[7:0];
    end else begin
      case (tx_idx[2:0])
        3'd3:    sel_byte = hdr[3];
        3'd4:    sel_byte = hdr[4];
        3'd5:    sel_byte = hdr[5];
        default: sel_byte = hdr[2];
      endcase
    end
  end

  always_comb begin
    state_next      = state;
    bit_cnt_next    = bit_cnt;
    len_next        = len;
    trailing_next   = trailing;
    crc_next        = crc;
    hdr_next        = hdr;
    dev_addr_next   = dev_addr;
    clr_addr_next   = clr_addr;
    frame_last_next = frame_last;
    is_read_next    = is_read;
    data_end_next   = data_end;
    tx_idx_next     = tx_idx;
    rd_ptr_next     = rd_ptr;
    out_valid_next  = out_valid && tx_stall;
    out_data_next   = out_data;
    ram_we          = 1'b0;
    ram_waddr       = reg_a[ADDR_W-1:0];
    ram_wdata       = reg_v;
    ram_re          = 1'b0;
    ram_raddr       = rd_ptr;
    load_last       = 1'b0;

    if (cfg_wr_en) begin
      dev_addr_next = cfg_wr_data;
    end

    case (state)
      S_CLEAR_MEM: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = 16'd0;
        if (clr_addr == ADDR_W'(REG_COUNT - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      S_IDLE: begin
        if (rx_valid) begin
          if (len < LEN_W'(6)) begin
            hdr_next[len[2:0]] = rx_data.rx_byte;
          end
          trailing_next   = {trailing[7:0], rx_data.rx_byte};
          frame_last_next = rx_data.frame_end;
          if (len != LEN_W'(MAX_FRAME + 1)) begin
            len_next = len + 1'b1;
          end
          if (len >= LEN_W'(2)) begin
            crc_next     = crc ^ {8'h00, trailing[15:8]};
            bit_cnt_next = 3'd0;
            state_next   = S_RX_SHIFT;
          end else if (rx_data.frame_end) begin
            state_next = S_CHECK;
          end
        end
      end
      S_RX_SHIFT: begin
        crc_next     = crc_step(crc);
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == 3'd7) begin
          state_next = frame_last ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        tx_idx_next = '0;
        rd_ptr_next = reg_a[ADDR_W-1:0];
        crc_next    = CRC_INIT;
        if (frame_ok && read_ok) begin
          is_read_next  = 1'b1;
          data_end_next = TX_IDX_W'({reg_v[7:0], 1'b0} + 9'd3);
          state_next    = S_TX_BYTE;
        end else if (frame_ok && write_ok) begin
          ram_we        = 1'b1;
          is_read_next  = 1'b0;
          data_end_next = TX_IDX_W'(6);
          state_next    = S_TX_BYTE;
        end else begin
          len_next      = '0;
          trailing_next = 16'd0;
          for (int i = 0; i < 6; i++) begin
            hdr_next[i] = 8'h00;
          end
          state_next = S_IDLE;
        end
      end
      S_RD_REQ: begin
        ram_re      = 1'b1;
        rd_ptr_next = rd_ptr + 1'b1;
        state_next  = S_TX_BYTE;
      end
      S_TX_BYTE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          if (tx_idx < data_end) begin
            out_data_next = '{tx_byte: sel_byte, tx_last: 1'b0};
            crc_next      = crc ^ {8'h00, sel_byte};
            bit_cnt_next  = 3'd0;
            state_next    = S_TX_SHIFT;
          end else if (tx_idx == data_end) begin
            out_data_next = '{tx_byte: crc[7:0], tx_last: 1'b0};
            tx_idx_next   = idx_inc;
          end else begin
            load_last     = 1'b1;
            out_data_next = '{tx_byte: crc[15:8], tx_last: 1'b1};
            crc_next      = CRC_INIT;
            len_next      = '0;
            trailing_next = 16'd0;
            for (int i = 0; i < 6; i++) begin
              hdr_next[i] = 8'h00;
            end
            state_next = S_IDLE;
          end
        end
      end
      S_TX_SHIFT: begin
        crc_next     = crc_step(crc);
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == 3'd7) begin
          tx_idx_next = idx_inc;
          if (is_read && idx_inc[0] && (idx_inc >= TX_IDX_W'(3)) && (idx_inc < data_end)) begin
            state_next = S_RD_REQ;
          end else begin
            state_next = S_TX_BYTE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR_MEM;
      bit_cnt   <= 3'd0;
      len       <= '0;
      trailing  <= 16'd0;
      crc       <= CRC_INIT;
      dev_addr  <= 8'd1;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        hdr[i] <= 8'h00;
      end
    end else begin
      state     <= state_next;
      bit_cnt   <= bit_cnt_next;
      len       <= len_next;
      trailing  <= trailing_next;
      crc       <= crc_next;
      dev_addr  <= dev_addr_next;
      clr_addr  <= clr_addr_next;
      out_valid <= out_valid_next;
      hdr       <= hdr_next;
    end
  end

  always_ff @(posedge clk) begin
    frame_last <= frame_last_next;
    is_read    <= is_read_next;
    data_end   <= data_end_next;
    tx_idx     <= tx_idx_next;
    rd_ptr     <= rd_ptr_next;
    out_data   <= out_data_next;
  end

`ifndef SYNTHESIS
  a_bit_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_RX_SHIFT && state != S_TX_SHIFT) |-> (bit_cnt == 3'd0))
    else $error("Bit counter is nonzero outside a shift state.");

  a_len_sat: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(MAX_FRAME + 1))
    else $error("Frame length passed its saturation value.");

  a_tx_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_TX_BYTE || state == S_TX_SHIFT || state == S_RD_REQ) |->
      (tx_idx <= data_end + 1'b1))
    else $error("Response index ran past the CRC bytes.");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    load_last |=> (state == S_IDLE && len == '0 && crc == CRC_INIT))
    else $error("Frame state not cleared after the final response byte.");

  a_ram_ports: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("Register file written and read in the same cycle.");
`endif

endmodule

`default_nettype wire

// File: test/tb.sv
// Testbench for modbus_rtu_slave_read_write_unit: request frames in, response bytes out.
// A built-in slave predictor checks every response byte. Depends on mbrw_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import mbrw_pkg::*;

  localparam int REG_COUNT = 64;
  localparam int MAX_READ = 16;
  localparam int MAX_FRAME = 256;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT = 500000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTS} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic rx_valid = 1'b0;
  logic rx_stall;
  rx_item_t rx_data = '0;
  logic tx_valid;
  logic tx_stall = 1'b0;
  tx_item_t tx_data;

  rx_item_t rx_bytes_q[$];
  tx_item_t reply_bytes_q[$];
  logic [7:0] frame_buf[$];
  tx_item_t exp_tx;

  logic rx_taken = 1'b0;
  int pushed_cnt = 0;
  int taken_cnt = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_timer = 0;
  stall_mode_t stall_mode = STALL_NONE;

  logic [15:0] reg_mem[REG_COUNT];
  logic [7:0] hdr[6];
  logic [15:0] crc_acc = CRC_INIT;
  logic [15:0] reply_crc;
  logic [15:0] tail = 16'h0000;
  int frame_len = 0;
  logic [7:0] dev_addr = 8'd1;

  modbus_rtu_slave_read_write_unit #(
    .REG_COUNT(REG_COUNT),
    .MAX_READ(MAX_READ),
    .MAX_FRAME(MAX_FRAME)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .rx_data(rx_data),
    .tx_valid(tx_valid),
    .tx_stall(tx_stall),
    .tx_data(tx_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic expect_reply_byte(input logic [7:0] b, input logic last);
    tx_item_t it;
    it.tx_byte = b;
    it.tx_last = last;
    reply_bytes_q.push_back(it);
    reply_crc = crc16_byte(reply_crc, b);
  endtask

  // Updates the slave state with one received byte and queues any response it causes.
  task automatic slave_take_byte(input rx_item_t it);
    int a;
    int v;
    bit replied;
    replied = 1'b0;
    if (frame_len < 6) begin
      hdr[frame_len] = it.rx_byte;
    end
    if (frame_len >= 2) begin
      crc_acc = crc16_byte(crc_acc, tail[15:8]);
    end
    tail = {tail[7:0], it.rx_byte};
    if (frame_len < MAX_FRAME + 1) begin
      frame_len++;
    end
    if (it.frame_end) begin
      if (frame_len >= 4 && frame_len <= MAX_FRAME && {tail[7:0], tail[15:8]} == crc_acc &&
          hdr[0] == dev_addr) begin
        a = int'({hdr[2], hdr[3]});
        v = int'({hdr[4], hdr[5]});
        reply_crc = CRC_INIT;
        if (hdr[1] == FN_READ && v != 0 && v <= MAX_READ && a + v <= REG_COUNT) begin
          expect_reply_byte(dev_addr, 1'b0);
          expect_reply_byte(FN_READ, 1'b0);
          expect_reply_byte(8'(v * 2), 1'b0);
          for (int j = 0; j < v; j++) begin
            expect_reply_byte(reg_mem[a + j][15:8], 1'b0);
            expect_reply_byte(reg_mem[a + j][7:0], 1'b0);
          end
          replied = 1'b1;
        end else if (hdr[1] == FN_WRITE && a < REG_COUNT) begin
          reg_mem[a] = v[15:0];
          expect_reply_byte(dev_addr, 1'b0);
          expect_reply_byte(FN_WRITE, 1'b0);
          for (int j = 2; j < 6; j++) begin
            expect_reply_byte(hdr[j], 1'b0);
          end
          replied = 1'b1;
        end
        if (replied) begin
          exp_tx.tx_byte = reply_crc[7:0];
          exp_tx.tx_last = 1'b0;
          reply_bytes_q.push_back(exp_tx);
          exp_tx.tx_byte = reply_crc[15:8];
          exp_tx.tx_last = 1'b1;
          reply_bytes_q.push_back(exp_tx);
        end
      end
      for (int j = 0; j < 6; j++) begin
        hdr[j] = 8'h00;
      end
      crc_acc = CRC_INIT;
      frame_len = 0;
      tail = 16'h0000;
    end
  endtask

  // Response check first, then prediction of the received transaction.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit");
      $display("Verification failed");
      $finish;
    end else begin
      if (!rst && tx_valid && !tx_stall) begin
        if (reply_bytes_q.size() == 0) begin
          report_error($sformatf("unexpected response byte %02h last %0b",
                                 tx_data.tx_byte, tx_data.tx_last));
        end else begin
          exp_tx = reply_bytes_q.pop_front();
          if (tx_data.tx_byte !== exp_tx.tx_byte) begin
            report_error($sformatf("tx_byte %02h, expected %02h",
                                   tx_data.tx_byte, exp_tx.tx_byte));
          end
          if (tx_data.tx_last !== exp_tx.tx_last) begin
            report_error($sformatf("tx_last %0b, expected %0b",
                                   tx_data.tx_last, exp_tx.tx_last));
          end
        end
      end
      rx_taken <= rx_valid && !rx_stall;
      if (rx_valid && !rx_stall) begin
        slave_take_byte(rx_data);
        taken_cnt <= taken_cnt + 1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (!rx_valid || rx_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        rx_valid <= 1'b0;
      end else if (rx_bytes_q.size() > 0) begin
        rx_data <= rx_bytes_q.pop_front();
        rx_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_timer == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_timer = $urandom_range(50, 300);
    end else begin
      stall_timer--;
    end
    case (stall_mode)
      STALL_NONE: tx_stall <= 1'b0;
      STALL_LIGHT: tx_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: tx_stall <= ($urandom_range(0, 3) != 0);
      default: tx_stall <= ((stall_timer % 16) < 9);
    endcase
  end

  task automatic set_address(input logic [7:0] a);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= a;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    dev_addr = a;
  endtask

  task automatic wait_quiet();
    while (taken_cnt != pushed_cnt || reply_bytes_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_frame(input bit add_crc, input bit corrupt);
    logic [15:0] c;
    rx_item_t it;
    c = CRC_INIT;
    if (add_crc) begin
      foreach (frame_buf[i]) begin
        c = crc16_byte(c, frame_buf[i]);
      end
      if (corrupt) begin
        c = c ^ (16'h0001 << $urandom_range(0, 15));
      end
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
    end
    foreach (frame_buf[i]) begin
      it.rx_byte = frame_buf[i];
      it.frame_end = (i == frame_buf.size() - 1);
      rx_bytes_q.push_back(it);
    end
    pushed_cnt += frame_buf.size();
    frame_buf.delete();
  endtask

  task automatic send_request(input logic [7:0] addr, input logic [7:0] fn,
                              input logic [15:0] w1, input logic [15:0] w2,
                              input int pad, input bit corrupt);
    frame_buf.push_back(addr);
    frame_buf.push_back(fn);
    frame_buf.push_back(w1[15:8]);
    frame_buf.push_back(w1[7:0]);
    frame_buf.push_back(w2[15:8]);
    frame_buf.push_back(w2[7:0]);
    repeat (pad) frame_buf.push_back(8'($urandom));
    send_frame(1'b1, corrupt);
  endtask

  task automatic random_traffic(input int n_bytes);
    int start;
    int kind;
    int stop_at;
    logic [7:0] fn;
    logic [7:0] wrong;
    stop_at = pushed_cnt + n_bytes;
    while (pushed_cnt < stop_at) begin
      kind = $urandom_range(0, 99);
      fn = 8'($urandom);
      if (fn == FN_READ || fn == FN_WRITE) begin
        fn = fn ^ 8'h80;
      end
      wrong = 8'($urandom_range(1, 255));
      start = $urandom_range(0, REG_COUNT - 1);
      if (kind < 35) begin
        send_request(dev_addr, FN_READ, 16'(start),
                     16'($urandom_range(1, (REG_COUNT - start < MAX_READ) ?
                                           REG_COUNT - start : MAX_READ)), 0, 1'b0);
      end else if (kind < 65) begin
        send_request(dev_addr, FN_WRITE, 16'(start), 16'($urandom), 0, 1'b0);
      end else if (kind < 70) begin
        send_request(dev_addr, FN_READ, 16'($urandom_range(0, 80)),
                     16'($urandom_range(0, 24)), 0, 1'b0);
      end else if (kind < 74) begin
        send_request(dev_addr, FN_WRITE, 16'($urandom_range(REG_COUNT, 65535)),
                     16'($urandom), 0, 1'b0);
      end else if (kind < 80) begin
        send_request(dev_addr, kind[0] ? FN_READ : FN_WRITE, 16'(start),
                     16'($urandom_range(1, 4)), 0, 1'b1);
      end else if (kind < 85) begin
        send_request(dev_addr ^ wrong, FN_WRITE, 16'(start), 16'($urandom), 0, 1'b0);
      end else if (kind < 89) begin
        send_request(dev_addr, fn, 16'(start), 16'($urandom_range(1, 4)), 0, 1'b0);
      end else if (kind < 93) begin
        repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom));
        send_frame(1'b0, 1'b0);
      end else if (kind < 96) begin
        frame_buf.push_back(dev_addr);
        frame_buf.push_back(kind[0] ? FN_READ : FN_WRITE);
        repeat ($urandom_range(0, 3)) frame_buf.push_back(8'($urandom_range(0, 3)));
        send_frame(1'b1, 1'b0);
      end else begin
        repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom));
        send_frame(1'b0, 1'b0);
      end
    end
  endtask

  initial begin
    for (int j = 0; j < REG_COUNT; j++) begin
      reg_mem[j] = 16'h0000;
    end
    for (int j = 0; j < 6; j++) begin
      hdr[j] = 8'h00;
    end
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    set_address(8'd1);
    send_request(dev_addr, FN_READ, 16'd0, 16'd1, 0, 1'b0);
    send_request(dev_addr, FN_WRITE, 16'd0, 16'hFFFF, 0, 1'b0);
    send_request(dev_addr, FN_WRITE, 16'd63, 16'h8001, 0, 1'b0);
    send_request(dev_addr, FN_READ, 16'd48, 16'd16, 0, 1'b0);
    send_request(dev_addr, FN_READ, 16'd0, 16'd0, 0, 1'b0);
    send_request(dev_addr, FN_READ, 16'd0, 16'd17, 0, 1'b0);
    send_request(dev_addr, FN_READ, 16'd60, 16'd5, 0, 1'b0);
    send_request(dev_addr, FN_WRITE, 16'd64, 16'h1234, 0, 1'b0);
    send_request(dev_addr, FN_WRITE, 16'hFFFF, 16'h1234, 0, 1'b0);
    send_request(dev_addr, 8'h10, 16'd0, 16'd1, 0, 1'b0);
    send_request(dev_addr, FN_WRITE, 16'd1, 16'h5555, 0, 1'b1);
    send_request(8'h00, FN_WRITE, 16'd2, 16'hAAAA, 0, 1'b0);
    send_request(8'd247, FN_WRITE, 16'd3, 16'h7E7E, 0, 1'b0);
    frame_buf.push_back(8'hFF);
    send_frame(1'b0, 1'b0);
    frame_buf.push_back(dev_addr);
    frame_buf.push_back(FN_READ);
    frame_buf.push_back(8'h00);
    send_frame(1'b0, 1'b0);
    frame_buf.push_back(dev_addr);
    frame_buf.push_back(FN_WRITE);
    send_frame(1'b1, 1'b0);
    frame_buf.push_back(dev_addr);
    frame_buf.push_back(FN_READ);
    frame_buf.push_back(8'h00);
    send_frame(1'b1, 1'b0);
    frame_buf.push_back(dev_addr);
    frame_buf.push_back(FN_WRITE);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h05);
    send_frame(1'b1, 1'b0);
    frame_buf.push_back(dev_addr);
    frame_buf.push_back(FN_READ);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h05);
    frame_buf.push_back(8'h00);
    send_frame(1'b1, 1'b0);
    wait_quiet();
    send_request(dev_addr, FN_READ, 16'd0, 16'd8, 0, 1'b0);
    wait_quiet();

    set_address(8'd247);
    random_traffic(10);
    wait_quiet();

    set_address(8'($urandom_range(2, 246)));
    random_traffic(10);
    wait_quiet();

    set_address(8'd1);
    random_traffic(8);
    wait_quiet();

    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/mbrw_pkg.sv
src/mbrw_ram.sv
src/modbus_rtu_slave_read_write_unit.sv
test/tb.sv
